/* rtl/core/bdc_pkg.sv */
// shared types, constants and arithmetic helpers of the b-dot detumble controller
package bdc_pkg;

  localparam int FIELD_W   = 24;
  localparam int RATE_W    = 24;
  localparam int STEP_W    = 20;
  localparam int GAIN_W    = 32;
  localparam int WEIGHT_W  = 17;
  localparam int LIMIT_W   = 15;
  localparam int MOMENT_W  = 16;
  localparam int WFRAC     = 16;
  localparam int RATE_FRAC = 20;
  localparam int GAIN_FRAC = 24;
  localparam int BN_W      = 16;
  localparam int SHIFT_W   = 4;
  localparam int DOT_W     = 50;
  localparam int N2_W      = 32;

  localparam int MA_W   = 64;
  localparam int MB_W   = 32;
  localparam int MCNT_W = 5;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SP_W   = PROD_W + 1;
  localparam int ACC_W  = SP_W + 1;
  localparam int DVD_W  = 66;
  localparam int DSR_W  = 32;
  localparam int DCNT_W = 7;
  localparam int M_W    = 35;
  localparam int S_W    = 32;

  localparam int IN_W  = 168;
  localparam int OUT_W = 48;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(1 << WFRAC);
  localparam logic [MB_W-1:0]     USEC_PER_SEC = MB_W'(1000000);

  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(16777216);
  localparam logic [WEIGHT_W-1:0] FILTER_RST = WEIGHT_W'(52429);
  localparam logic [WEIGHT_W-1:0] FUSION_RST = WEIGHT_W'(32768);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(32767);

  typedef enum logic [1:0] {
    REG_GAIN, REG_FILTER, REG_FUSION, REG_LIMIT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_DIFF, S_DIV_DERIV, S_FILT_A, S_FILT_B, S_GYRO_A, S_GYRO_B,
    S_BLEND_A, S_BLEND_B, S_MOMENT, S_NORM, S_DOT, S_NORM2, S_PROJ_MUL,
    S_PROJ_DIV, S_DONE
  } state_t;

  typedef struct packed {
    logic            start;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
    logic            neg;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  function automatic logic [ACC_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  function automatic logic signed [S_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic fits;
    fits = (&v[ACC_W-1:S_W-1]) || !(|v[ACC_W-1:S_W-1]);
    if (fits) return v[S_W-1:0];
    return v[ACC_W-1] ? {1'b1, {(S_W-1){1'b0}}} : {1'b0, {(S_W-1){1'b1}}};
  endfunction

  function automatic logic signed [S_W-1:0] satm(input logic signed [ACC_W-1:0] v);
    logic signed [S_W-1:0] s;
    s = sat32(v);
    if (s == {1'b1, {(S_W-1){1'b0}}}) return {1'b1, {(S_W-2){1'b0}}, 1'b1};
    return s;
  endfunction

  function automatic logic [MOMENT_W-1:0] clamp(input logic signed [M_W-1:0] v,
                                                input logic [LIMIT_W-1:0] lim);
    logic signed [M_W-1:0] hi;
    logic signed [M_W-1:0] lo;
    hi = $signed(M_W'(lim));
    lo = -hi;
    if (v > hi) return MOMENT_W'(hi);
    if (v < lo) return MOMENT_W'(lo);
    return MOMENT_W'(v);
  endfunction

endpackage

/* rtl/core/bdc_mul.sv */
// bit-serial shift-add multiplier, sign-magnitude operands, one multiplier bit per cycle
module bdc_mul import bdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mul_req_t               req,
  output logic                   done,
  output logic signed [SP_W-1:0] prod
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [MA_W-1:0]   a_r, a_nxt;
  logic [MB_W-1:0]   b_r, b_nxt;
  logic              neg_r, neg_nxt;
  logic [MA_W:0]     hi;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    neg_nxt  = neg_r;
    hi = {1'b0, acc_r[PROD_W-1:MB_W]} + (b_r[0] ? {1'b0, a_r} : '0);
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      acc_nxt = {hi, acc_r[MB_W-1:1]};
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MCNT_W'(MB_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

/* rtl/core/bdc_div.sv */
// restoring divider for unsigned magnitudes, one quotient bit per cycle
module bdc_div import bdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DVD_W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W:0]    cat;
  logic              qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cat  = {rem_r, dvd_r[DVD_W-1]};
    qbit = cat >= {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = qbit ? DSR_W'(cat - {1'b0, dsr_r}) : DSR_W'(cat);
      dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

/* rtl/core/bdot_detumble_controller.sv */
// top level of the b-dot detumble controller: sequencer, state and channels
//
// in_*  : one request per magnetometer sample (field, gyro rate, step time).
// out_* : one commanded moment per request; out_tuser flags a priming sample.
// cfg_* : register writes (gain, filter weight, fusion weight, moment limit),
//         always ready, to be written only while the block is idle.
// A priming request (stored field all zero) goes from acceptance straight to
// the final step, which moves its result into the output register. A full
// request runs one shared bit-serial multiplier and one serial divider:
// 8 products and one quotient per axis, then, for a nonzero field, a field
// normalize and 6 products for the dot and norm terms, then, if the norm is
// nonzero, a product and a quotient per axis for the projection. One
// request is processed at a time.
// in_tready is high only while idle. A finished result moves to the output
// register; while a stalled receiver still holds that register the block waits
// in its last step and takes no new request until the register frees.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// stored field and filtered derivative and empties the output register.
module bdot_detumble_controller import bdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // field_x, field_y, field_z, rate_x, rate_y, rate_z, step_time, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // moment_x, moment_y, moment_z
  output logic [OUT_W-1:0] out_tdata,
  // priming
  output logic [0:0]       out_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]   gain_r;
  logic [WEIGHT_W-1:0] fw_r, uw_r;
  logic [LIMIT_W-1:0]  lim_r;

  logic signed [FIELD_W-1:0] b_r [3], b_nxt [3];
  logic signed [RATE_W-1:0]  w_r [3], w_nxt [3];
  logic signed [FIELD_W-1:0] prev_r [3], prev_nxt [3];
  logic signed [S_W-1:0]     f_r [3], f_nxt [3];
  logic signed [M_W-1:0]     m_r [3], m_nxt [3];
  logic signed [BN_W-1:0]    bn_r [3], bn_nxt [3];
  logic [STEP_W-1:0]         dt_r, dt_nxt;
  logic [1:0]                ax_r, ax_nxt;
  logic [SHIFT_W-1:0]        s_r, s_nxt;
  logic                      iss_r, iss_nxt;
  logic                      prime_r, prime_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [S_W-1:0]     d_r, d_nxt;
  logic signed [S_W-1:0]     gy_r, gy_nxt;
  logic signed [S_W-1:0]     bl_r, bl_nxt;
  logic signed [DOT_W-1:0]   dot_r, dot_nxt;
  logic [N2_W-1:0]           n2_r, n2_nxt;
  logic                      ov_r, ov_nxt;
  logic [OUT_W-1:0]          od_r, od_nxt;
  logic                      ou_r, ou_nxt;

  mul_req_t                mreq;
  div_req_t                dreq;
  logic                    mul_done, div_done;
  logic signed [SP_W-1:0]  mul_prod;
  logic [DVD_W-1:0]        div_quot;
  logic signed [ACC_W-1:0] p_ext, q_s;
  logic [WEIGHT_W-1:0]     fa, fa_c, fb, fb_c;

  bdc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mul_done), .prod(mul_prod));
  bdc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(div_done), .quot(div_quot));

  assign p_ext = ACC_W'(mul_prod);
  assign q_s   = acc_r[ACC_W-1] ? -$signed(ACC_W'(div_quot)) : $signed(ACC_W'(div_quot));
  assign fa    = (fw_r > WEIGHT_ONE) ? WEIGHT_ONE : fw_r;
  assign fb    = (uw_r > WEIGHT_ONE) ? WEIGHT_ONE : uw_r;
  assign fa_c  = WEIGHT_ONE - fa;
  assign fb_c  = WEIGHT_ONE - fb;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  always_comb begin
    logic signed [ACC_W-1:0]   diff;
    logic signed [ACC_W-1:0]   sum;
    logic signed [M_W-1:0]     mnew;
    logic signed [FIELD_W-1:0] cand [3];
    logic                      fits;
    logic                      b_nz;
    logic                      advance;

    state_nxt = state_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    prev_nxt  = prev_r;
    f_nxt     = f_r;
    m_nxt     = m_r;
    bn_nxt    = bn_r;
    dt_nxt    = dt_r;
    ax_nxt    = ax_r;
    s_nxt     = s_r;
    iss_nxt   = iss_r;
    prime_nxt = prime_r;
    acc_nxt   = acc_r;
    d_nxt     = d_r;
    gy_nxt    = gy_r;
    bl_nxt    = bl_r;
    dot_nxt   = dot_r;
    n2_nxt    = n2_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    mreq      = '0;
    dreq      = '0;
    diff      = '0;
    sum       = '0;
    mnew      = '0;
    fits      = 1'b1;
    advance   = 1'b0;
    b_nz      = (b_r[0] != '0) || (b_r[1] != '0) || (b_r[2] != '0);
    for (int i = 0; i < 3; i++) begin
      cand[i] = b_r[i] >>> s_r;
      if (!((&cand[i][FIELD_W-1:BN_W-1]) || !(|cand[i][FIELD_W-1:BN_W-1]))) fits = 1'b0;
    end

    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          b_nxt[0] = $signed(in_tdata[23:0]);
          b_nxt[1] = $signed(in_tdata[47:24]);
          b_nxt[2] = $signed(in_tdata[71:48]);
          w_nxt[0] = $signed(in_tdata[95:72]);
          w_nxt[1] = $signed(in_tdata[119:96]);
          w_nxt[2] = $signed(in_tdata[143:120]);
          dt_nxt   = (in_tdata[163:144] == '0) ? STEP_W'(1) : in_tdata[163:144];
          ax_nxt   = '0;
          iss_nxt  = 1'b0;
          if (prev_r[0] == '0 && prev_r[1] == '0 && prev_r[2] == '0) begin
            prime_nxt = 1'b1;
            for (int i = 0; i < 3; i++) m_nxt[i] = '0;
            state_nxt = S_DONE;
          end else begin
            prime_nxt = 1'b0;
            state_nxt = S_MUL_DIFF;
          end
        end
      end
      S_MUL_DIFF: begin
        diff = ACC_W'(b_r[0]) - ACC_W'(prev_r[0]);
        mreq = '{start: !iss_r, a: MA_W'(mag_of(diff)), b: USEC_PER_SEC,
                 neg: diff[ACC_W-1]};
        if (mul_done) begin
          acc_nxt   = p_ext;
          state_nxt = S_DIV_DERIV;
        end
      end
      S_DIV_DERIV: begin
        dreq = '{start: !iss_r, dividend: DVD_W'(mag_of(acc_r)),
                 divisor: DSR_W'(dt_r)};
        if (div_done) begin
          d_nxt     = sat32(q_s);
          state_nxt = S_FILT_A;
        end
      end
      S_FILT_A: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(d_r))), b: MB_W'(fa_c),
                 neg: d_r[S_W-1]};
        if (mul_done) begin
          acc_nxt   = p_ext;
          state_nxt = S_FILT_B;
        end
      end
      S_FILT_B: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(f_r[0]))), b: MB_W'(fa),
                 neg: f_r[0][S_W-1]};
        if (mul_done) begin
          sum       = acc_r + p_ext;
          f_nxt[0]  = sat32(sum >>> WFRAC);
          state_nxt = S_GYRO_A;
        end
      end
      S_GYRO_A: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(b_r[1]))),
                 b: MB_W'(mag_of(ACC_W'(w_r[2]))),
                 neg: b_r[1][FIELD_W-1] ^ w_r[2][RATE_W-1]};
        if (mul_done) begin
          acc_nxt   = p_ext;
          state_nxt = S_GYRO_B;
        end
      end
      S_GYRO_B: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(b_r[2]))),
                 b: MB_W'(mag_of(ACC_W'(w_r[1]))),
                 neg: b_r[2][FIELD_W-1] ^ w_r[1][RATE_W-1]};
        if (mul_done) begin
          sum       = acc_r - p_ext;
          gy_nxt    = sat32(sum >>> RATE_FRAC);
          state_nxt = S_BLEND_A;
        end
      end
      S_BLEND_A: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(gy_r))), b: MB_W'(fb_c),
                 neg: gy_r[S_W-1]};
        if (mul_done) begin
          acc_nxt   = p_ext;
          state_nxt = S_BLEND_B;
        end
      end
      S_BLEND_B: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(f_r[0]))), b: MB_W'(fb),
                 neg: f_r[0][S_W-1]};
        if (mul_done) begin
          sum       = acc_r + p_ext;
          bl_nxt    = sat32(sum >>> WFRAC);
          state_nxt = S_MOMENT;
        end
      end
      S_MOMENT: begin
        mreq = '{start: !iss_r, a: MA_W'(gain_r), b: MB_W'(mag_of(ACC_W'(bl_r))),
                 neg: bl_r[S_W-1]};
        if (mul_done) begin
          sum  = -p_ext;
          mnew = M_W'(satm(sum >>> GAIN_FRAC));
          // rotate so the next axis sits in slot zero
          for (int i = 0; i < 2; i++) begin
            b_nxt[i]    = b_r[i+1];
            w_nxt[i]    = w_r[i+1];
            prev_nxt[i] = prev_r[i+1];
            f_nxt[i]    = f_r[i+1];
            m_nxt[i]    = m_r[i+1];
          end
          b_nxt[2]    = b_r[0];
          w_nxt[2]    = w_r[0];
          prev_nxt[2] = prev_r[0];
          f_nxt[2]    = f_r[0];
          m_nxt[2]    = mnew;
          if (ax_r == 2'd2) begin
            ax_nxt    = '0;
            s_nxt     = '0;
            state_nxt = b_nz ? S_NORM : S_DONE;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = S_MUL_DIFF;
          end
        end
      end
      S_NORM: begin
        if (fits) begin
          for (int i = 0; i < 3; i++) bn_nxt[i] = BN_W'(cand[i]);
          acc_nxt   = '0;
          state_nxt = S_DOT;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      S_DOT: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(m_r[0]))),
                 b: MB_W'(mag_of(ACC_W'(bn_r[0]))),
                 neg: m_r[0][M_W-1] ^ bn_r[0][BN_W-1]};
        if (mul_done) begin
          sum     = acc_r + p_ext;
          acc_nxt = sum;
          advance = 1'b1;
          for (int i = 0; i < 2; i++) m_nxt[i] = m_r[i+1];
          m_nxt[2] = m_r[0];
          if (ax_r == 2'd2) begin
            dot_nxt   = DOT_W'(sum);
            acc_nxt   = '0;
            ax_nxt    = '0;
            state_nxt = S_NORM2;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end
      end
      S_NORM2: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(bn_r[0]))),
                 b: MB_W'(mag_of(ACC_W'(bn_r[0]))), neg: 1'b0};
        if (mul_done) begin
          sum     = acc_r + p_ext;
          acc_nxt = sum;
          advance = 1'b1;
          if (ax_r == 2'd2) begin
            n2_nxt    = N2_W'(sum);
            ax_nxt    = '0;
            state_nxt = (N2_W'(sum) == '0) ? S_DONE : S_PROJ_MUL;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end
      end
      S_PROJ_MUL: begin
        mreq = '{start: !iss_r, a: MA_W'(mag_of(ACC_W'(dot_r))),
                 b: MB_W'(mag_of(ACC_W'(bn_r[0]))),
                 neg: dot_r[DOT_W-1] ^ bn_r[0][BN_W-1]};
        if (mul_done) begin
          acc_nxt   = p_ext;
          state_nxt = S_PROJ_DIV;
        end
      end
      S_PROJ_DIV: begin
        dreq = '{start: !iss_r, dividend: DVD_W'(mag_of(acc_r)), divisor: n2_r};
        if (div_done) begin
          mnew    = m_r[0] - M_W'(q_s);
          advance = 1'b1;
          for (int i = 0; i < 2; i++) m_nxt[i] = m_r[i+1];
          m_nxt[2] = mnew;
          if (ax_r == 2'd2) begin
            ax_nxt    = '0;
            state_nxt = S_DONE;
          end else begin
            ax_nxt    = ax_r + 1'b1;
            state_nxt = S_PROJ_MUL;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = {clamp(m_r[2], lim_r), clamp(m_r[1], lim_r), clamp(m_r[0], lim_r)};
          ou_nxt    = prime_r;
          prev_nxt  = b_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (advance) begin
      for (int i = 0; i < 2; i++) bn_nxt[i] = bn_r[i+1];
      bn_nxt[2] = bn_r[0];
    end
    if (mreq.start || dreq.start) iss_nxt = 1'b1;
    if (mul_done || div_done) iss_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
        f_r[i]    <= '0;
      end
    end else begin
      iss_r  <= iss_nxt;
      ov_r   <= ov_nxt;
      prev_r <= prev_nxt;
      f_r    <= f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      fw_r   <= FILTER_RST;
      uw_r   <= FUSION_RST;
      lim_r  <= LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN:   gain_r <= cfg_data[GAIN_W-1:0];
        REG_FILTER: fw_r   <= cfg_data[WEIGHT_W-1:0];
        REG_FUSION: uw_r   <= cfg_data[WEIGHT_W-1:0];
        REG_LIMIT:  lim_r  <= cfg_data[LIMIT_W-1:0];
        default:    gain_r <= gain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    w_r     <= w_nxt;
    m_r     <= m_nxt;
    bn_r    <= bn_nxt;
    dt_r    <= dt_nxt;
    ax_r    <= ax_nxt;
    s_r     <= s_nxt;
    prime_r <= prime_nxt;
    acc_r   <= acc_nxt;
    d_r     <= d_nxt;
    gy_r    <= gy_nxt;
    bl_r    <= bl_nxt;
    dot_r   <= dot_nxt;
    n2_r    <= n2_nxt;
    od_r    <= od_nxt;
    ou_r    <= ou_nxt;
  end

  a_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("priming result carries a nonzero moment");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while a request is in progress");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_DERIV || state_r == S_PROJ_DIV))
    else $error("divider finished outside a divide step");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mreq.start && dreq.start))
    else $error("multiplier and divider started together");

endmodule

/* test/tb_bdot_detumble_controller.sv */
// testbench of the b-dot detumble controller: random and directed requests checked against a predictor
class moment_scoreboard;
  logic [47:0] exp_data[$];
  logic        exp_prime[$];
  int          errors;

  longint prev_b[3];
  longint filt[3];
  longint gain, fw, uw, lim;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function void reset_state();
    gain = 16777216; fw = 52429; uw = 32768; lim = 32767;
    for (int i = 0; i < 3; i++) begin
      prev_b[i] = 0;
      filt[i] = 0;
    end
    errors = 0;
  endfunction

  function void write_reg(bdc_pkg::cfg_reg_t idx, logic [31:0] v);
    case (idx)
      bdc_pkg::REG_GAIN: gain = v;
      bdc_pkg::REG_FILTER: fw = v[16:0];
      bdc_pkg::REG_FUSION: uw = v[16:0];
      default: lim = v[14:0];
    endcase
  endfunction

  function void note_request(logic [167:0] d);
    longint b[3], w[3], g[3], m[3], bn[3];
    longint one, fa, fb, dt, dd, gy, bl, dot, n2;
    logic [47:0] r;
    int s;
    logic fits;
    one = 65536;
    fa = fw > one ? one : fw;
    fb = uw > one ? one : uw;
    for (int i = 0; i < 3; i++) begin
      b[i] = longint'($signed(d[24*i +: 24]));
      w[i] = longint'($signed(d[72 + 24*i +: 24]));
    end
    dt = d[163:144];
    if (dt == 0) dt = 1;
    if (prev_b[0] == 0 && prev_b[1] == 0 && prev_b[2] == 0) begin
      for (int i = 0; i < 3; i++) prev_b[i] = b[i];
      exp_data.push_back('0);
      exp_prime.push_back(1'b1);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      dd = sat(((b[i] - prev_b[i]) * 1000000) / dt, -64'sd2147483648, 64'sd2147483647);
      filt[i] = sat(((one - fa) * dd + fa * filt[i]) >>> 16, -64'sd2147483648,
                    64'sd2147483647);
    end
    g[0] = b[1] * w[2] - b[2] * w[1];
    g[1] = b[2] * w[0] - b[0] * w[2];
    g[2] = b[0] * w[1] - b[1] * w[0];
    for (int i = 0; i < 3; i++) begin
      gy = sat(g[i] >>> 20, -64'sd2147483648, 64'sd2147483647);
      bl = sat(((one - fb) * gy + fb * filt[i]) >>> 16, -64'sd2147483648, 64'sd2147483647);
      m[i] = sat((-(gain * bl)) >>> 24, -64'sd2147483647, 64'sd2147483647);
    end
    if (b[0] != 0 || b[1] != 0 || b[2] != 0) begin
      s = 0;
      forever begin
        fits = 1'b1;
        for (int i = 0; i < 3; i++) begin
          bn[i] = b[i] >>> s;
          if (bn[i] > 32767 || bn[i] < -32768) fits = 1'b0;
        end
        if (fits || s >= 40) break;
        s++;
      end
      dot = bn[0] * m[0] + bn[1] * m[1] + bn[2] * m[2];
      n2 = bn[0] * bn[0] + bn[1] * bn[1] + bn[2] * bn[2];
      if (n2 != 0)
        for (int i = 0; i < 3; i++) m[i] = m[i] - (bn[i] * dot) / n2;
    end
    for (int i = 0; i < 3; i++) begin
      prev_b[i] = b[i];
      r[16*i +: 16] = 16'(sat(m[i], -lim, lim));
    end
    exp_data.push_back(r);
    exp_prime.push_back(1'b0);
  endfunction

  function void check_result(logic [47:0] d, logic p);
    logic [47:0] ed;
    logic ep;
    if (exp_data.size() == 0) begin
      $display("%0t unexpected result: actual %h/%b", $time, d, p);
      errors++;
      return;
    end
    ed = exp_data.pop_front();
    ep = exp_prime.pop_front();
    for (int i = 0; i < 3; i++)
      if (ed[16*i +: 16] !== d[16*i +: 16]) begin
        $display("%0t moment axis %0d: expected %0d actual %0d", $time, i,
                 $signed(ed[16*i +: 16]), $signed(d[16*i +: 16]));
        errors++;
      end
    if (ep !== p) begin
      $display("%0t priming: expected %b actual %b", $time, ep, p);
      errors++;
    end
  endfunction
endclass

module tb_bdot_detumble_controller;
  import bdc_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         calm = 0;

  moment_scoreboard sb;

  bdot_detumble_controller i_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk)
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);

  always @(negedge clk)
    out_tready <= calm || ($urandom_range(99) >= 21);

  task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic send(logic signed [23:0] b[3], logic signed [23:0] w[3], logic [19:0] st);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 21) @(negedge clk);
    in_tdata <= {4'b0, st, w[2], w[1], w[0], b[2], b[1], b[0]};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  function automatic logic signed [23:0] rnd_field(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(4000)) - 2000);
      default: return 24'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic rnd_request(int mode);
    logic signed [23:0] b[3], w[3];
    logic [19:0] st;
    for (int i = 0; i < 3; i++) begin
      b[i] = rnd_field(mode);
      w[i] = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(40000)) - 20000);
    end
    if ($urandom_range(30) == 0) b = '{24'sd0, 24'sd0, 24'sd0};
    st = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 200000));
    if ($urandom_range(40) == 0) st = 0;
    send(b, w, st);
  endtask

  task automatic drain();
    while (sb.exp_data.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic signed [23:0] b[3], w[3];
    sb = new();
    sb.reset_state();
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: priming, extremes, zero field, zero step, saturation
    b = '{24'sh7fffff, -24'sh800000, 24'sd1}; w = '{24'sh7fffff, -24'sh800000, 24'sd0};
    send(b, w, 20'd1);
    b = '{-24'sh800000, 24'sh7fffff, 24'sh7fffff}; w = '{-24'sh800000, 24'sh7fffff, 24'sh7fffff};
    send(b, w, 20'd1);
    b = '{24'sd100, 24'sd0, -24'sd50}; w = '{24'sd0, 24'sd0, 24'sd0};
    send(b, w, 20'd0);
    send(b, w, 20'hfffff);
    b = '{24'sd0, 24'sd0, 24'sd0};
    send(b, w, 20'd10);
    b = '{24'sd30000, 24'sd20000, -24'sd10000}; w = '{24'sd1000, -24'sd2000, 24'sd3000};
    send(b, w, 20'd100);
    b = '{24'sd31000, 24'sd19000, -24'sd11000};
    send(b, w, 20'd100);
    drain();
    write_reg(REG_GAIN, 32'hffffffff);
    write_reg(REG_FILTER, 32'h1ffff);
    write_reg(REG_FUSION, 32'd0);
    write_reg(REG_LIMIT, 32'd0);
    for (int k = 0; k < 4; k++) rnd_request(k % 3);
    drain();
    write_reg(REG_LIMIT, 32'h7fff);
    write_reg(REG_FILTER, 32'd0);
    write_reg(REG_FUSION, 32'd65536);
    for (int k = 0; k < 6; k++) rnd_request(k % 3);
    drain();
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_FUSION, 32'h1ffff);
    for (int k = 0; k < 3; k++) rnd_request(1);
    drain();
    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_GAIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 26));
      write_reg(REG_FILTER, $urandom_range(3) == 0 ? 32'($urandom_range(131071))
                                                   : 32'($urandom_range(65536)));
      write_reg(REG_FUSION, $urandom_range(3) == 0 ? 32'($urandom_range(131071))
                                                   : 32'($urandom_range(65536)));
      write_reg(REG_LIMIT, ph == 3 ? 32'($urandom_range(32767)) : 32'($urandom));
      calm = (ph == 5);
      for (int k = 0; k < 48; k++) rnd_request($urandom_range(2));
      drain();
      calm = 0;
    end
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #12000000;
    $display("status: fail");
    $finish;
  end
endmodule
